// File: src/tsf_pkg.sv
// Shared types and constants for the thousands separator formatter.
// Used by tsf_ctrl, tsf_datapath and thousands_separator_formatter; no dependencies.
`timescale 1ns / 1ps

package tsf_pkg;

	localparam int VALUE_W   = 31;
	localparam int DIGITS    = 10;
	localparam int BCD_W     = 4 * DIGITS;
	localparam int CHAR_W    = 8;
	localparam int STEP_W    = 5;
	localparam int POS_W     = 4;

	localparam logic [CHAR_W-1:0] ZERO_CHAR = 8'h30;
	localparam logic [CHAR_W-1:0] SEP_CHAR  = 8'h2C;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_COUNT,
		ST_EMIT_DIGIT,
		ST_EMIT_COMMA
	} state_t;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic set_pos;
		logic dec_pos;
		logic emit_digit;
		logic emit_comma;
	} cmd_t;

	typedef struct packed {
		logic conv_done;
		logic pos_zero;
		logic comma_next;
	} status_t;

endpackage

// File: src/thousands_separator_formatter.sv
// Start is taken in idle and the value is loaded at the accepting edge; then come 31
// shift-add-3 steps, 1 digit count and the output register before the first character appears;
// then one character per cycle, up to 13.
// The serial BCD converter takes no new start while an item is in progress: busy stays high
// until the last character has been registered.
// Reset: arst_n clears the controller, the step and digit counters and the strobe at once.
// The receiver cannot stall: each character is shown for exactly one cycle with strobe high.
`timescale 1ns / 1ps

module thousands_separator_formatter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [tsf_pkg::VALUE_W-1:0] value,
	output logic                        strobe,
	output logic [tsf_pkg::CHAR_W-1:0]  text_char,
	output logic                        is_last
);

	tsf_pkg::cmd_t    cmd;
	tsf_pkg::status_t status;

	tsf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	tsf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.status    (status),
		.strobe    (strobe),
		.text_char (text_char),
		.is_last   (is_last)
	);

endmodule

// File: src/tsf_ctrl.sv
// Controller state machine for the thousands separator formatter.
// Depends on tsf_pkg; drives tsf_datapath through command and status structs.
`timescale 1ns / 1ps

module tsf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  tsf_pkg::status_t status,
	output tsf_pkg::cmd_t    cmd,
	output logic             busy
);

	tsf_pkg::state_t state_q;
	tsf_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsf_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		busy       = 1'b1;
		case (state_q)
			tsf_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load   = 1'b1;
					state_next = tsf_pkg::ST_CONVERT;
				end
			end
			tsf_pkg::ST_CONVERT: begin
				cmd.conv_step = 1'b1;
				if (status.conv_done) begin
					state_next = tsf_pkg::ST_COUNT;
				end
			end
			tsf_pkg::ST_COUNT: begin
				cmd.set_pos = 1'b1;
				state_next  = tsf_pkg::ST_EMIT_DIGIT;
			end
			tsf_pkg::ST_EMIT_DIGIT: begin
				cmd.emit_digit = 1'b1;
				if (status.pos_zero) begin
					state_next = tsf_pkg::ST_IDLE;
				end else begin
					cmd.dec_pos = 1'b1;
					state_next  = status.comma_next ? tsf_pkg::ST_EMIT_COMMA
					                                : tsf_pkg::ST_EMIT_DIGIT;
				end
			end
			tsf_pkg::ST_EMIT_COMMA: begin
				cmd.emit_comma = 1'b1;
				state_next     = tsf_pkg::ST_EMIT_DIGIT;
			end
			default: begin
				state_next = tsf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: src/tsf_datapath.sv
// Datapath: shift-add-3 binary to BCD converter, digit pointer and output registers.
// Depends on tsf_pkg; commanded by tsf_ctrl.
`timescale 1ns / 1ps

module tsf_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [tsf_pkg::VALUE_W-1:0]    value,
	input  tsf_pkg::cmd_t                  cmd,
	output tsf_pkg::status_t               status,
	output logic                           strobe,
	output logic [tsf_pkg::CHAR_W-1:0]     text_char,
	output logic                           is_last
);

	logic [tsf_pkg::VALUE_W-1:0] bin_q;
	logic [tsf_pkg::BCD_W-1:0]   bcd_q;
	logic [tsf_pkg::BCD_W-1:0]   bcd_adj;
	logic [tsf_pkg::STEP_W-1:0]  step_q;
	logic [tsf_pkg::POS_W-1:0]   pos_q;
	logic [tsf_pkg::POS_W-1:0]   msd_pos;
	logic [3:0]                  cur_digit;
	logic                        strobe_q;
	logic [tsf_pkg::CHAR_W-1:0]  char_q;
	logic                        last_q;

	always_comb begin
		for (int d = 0; d < tsf_pkg::DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] >= 4'd5) begin
				bcd_adj[d*4 +: 4] = bcd_q[d*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[d*4 +: 4] = bcd_q[d*4 +: 4];
			end
		end
	end

	always_comb begin
		msd_pos = '0;
		for (int d = 0; d < tsf_pkg::DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0) begin
				msd_pos = tsf_pkg::POS_W'(d);
			end
		end
	end

	always_comb begin
		case (pos_q)
			4'd0:    cur_digit = bcd_q[3:0];
			4'd1:    cur_digit = bcd_q[7:4];
			4'd2:    cur_digit = bcd_q[11:8];
			4'd3:    cur_digit = bcd_q[15:12];
			4'd4:    cur_digit = bcd_q[19:16];
			4'd5:    cur_digit = bcd_q[23:20];
			4'd6:    cur_digit = bcd_q[27:24];
			4'd7:    cur_digit = bcd_q[31:28];
			4'd8:    cur_digit = bcd_q[35:32];
			4'd9:    cur_digit = bcd_q[39:36];
			default: cur_digit = 4'd0;
		endcase
	end

	always_comb begin
		status.conv_done  = (step_q == '0);
		status.pos_zero   = (pos_q == '0);
		status.comma_next = (pos_q == 4'd3) || (pos_q == 4'd6) || (pos_q == 4'd9);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (cmd.conv_step) begin
			bin_q <= {bin_q[tsf_pkg::VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[tsf_pkg::BCD_W-2:0], bin_q[tsf_pkg::VALUE_W-1]};
		end
		if (cmd.emit_digit) begin
			char_q <= tsf_pkg::ZERO_CHAR + {4'd0, cur_digit};
			last_q <= (pos_q == '0);
		end else if (cmd.emit_comma) begin
			char_q <= tsf_pkg::SEP_CHAR;
			last_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			pos_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				step_q <= tsf_pkg::LAST_STEP;
			end else if (cmd.conv_step && (step_q != '0)) begin
				step_q <= step_q - 1'b1;
			end
			if (cmd.set_pos) begin
				pos_q <= msd_pos;
			end else if (cmd.dec_pos) begin
				pos_q <= pos_q - 1'b1;
			end
			strobe_q <= cmd.emit_digit | cmd.emit_comma;
		end
	end

	assign strobe    = strobe_q;
	assign text_char = char_q;
	assign is_last   = last_q;

endmodule
